// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the header key/value extractor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, skipped while in reset.
`define HKV_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Check a property on every rising clock edge, reset included.
`define HKV_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

// ===== rtl/hkv_pkg.sv =====
// Shared types, constants and helpers of the header key/value extractor.
package hkv_pkg;

	localparam int unsigned KEY_BYTES_DEF = 8;

	localparam int unsigned KEY_TEXT_W  = 64;
	localparam int unsigned KEY_LEN_W   = 4;
	localparam int unsigned WORD_IDX_W  = 9;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned CFG_DATA_W  = KEY_TEXT_W;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned LEN_W       = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_TEXT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WORD_INDEX = 2'd2;

	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;

	localparam logic [WORD_IDX_W-1:0] WORD_REST_OF_LINE = '1;

	typedef struct packed {
		logic [KEY_TEXT_W-1:0] key_text;
		logic [KEY_LEN_W-1:0]  key_length;
		logic [WORD_IDX_W-1:0] word_index;
	} hkv_cfg_t;

	function automatic logic is_blank(input logic [BYTE_W-1:0] b);
		return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF);
	endfunction

endpackage

// ===== rtl/hkv_in_if.sv =====
// Input channel: one text byte or an end-of-string marker per transfer.
interface hkv_in_if;
	logic                      valid;
	logic                      ready;
	logic [hkv_pkg::BYTE_W-1:0] text_byte;
	logic                      string_end;

	modport source (output valid, output text_byte, output string_end, input ready);
	modport sink (input valid, input text_byte, input string_end, output ready);
endinterface

// ===== rtl/hkv_out_if.sv =====
// Result channel: one extracted byte or a finished marker with length per transfer.
interface hkv_out_if;
	logic                       valid;
	logic                       ready;
	logic [hkv_pkg::BYTE_W-1:0] out_byte;
	logic                       finished;
	logic [hkv_pkg::LEN_W-1:0]  out_length;

	modport source (output valid, output out_byte, output finished, output out_length,
		input ready);
	modport sink (input valid, input out_byte, input finished, input out_length,
		output ready);
endinterface

// ===== rtl/hkv_cfg.sv =====
// Configuration registers of the header key/value extractor.
module hkv_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [hkv_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [hkv_pkg::CFG_DATA_W-1:0]    wr_data,
	output hkv_pkg::hkv_cfg_t                 cfg
);
	import hkv_pkg::*;

	hkv_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_text   <= '0;
			cfg_q.key_length <= KEY_LEN_W'(1);
			cfg_q.word_index <= WORD_REST_OF_LINE;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_KEY_TEXT:   cfg_q.key_text   <= wr_data[KEY_TEXT_W-1:0];
				CFG_KEY_LENGTH: cfg_q.key_length <= wr_data[KEY_LEN_W-1:0];
				CFG_WORD_INDEX: cfg_q.word_index <= wr_data[WORD_IDX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/hkv_core.sv =====
// Input register, scan state machine and result register of the extractor.
`include "assert_macros.svh"

module hkv_core #(
	parameter int unsigned KeyBytes = hkv_pkg::KEY_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  hkv_pkg::hkv_cfg_t cfg,
	hkv_in_if.sink            text,
	hkv_out_if.source         result
);
	import hkv_pkg::*;

	localparam int unsigned KIDX_W = (KeyBytes > 1) ? $clog2(KeyBytes) : 1;

	typedef enum logic [1:0] {
		PH_SEEK,
		PH_COUNT,
		PH_EMIT,
		PH_DONE
	} phase_t;

	// input stage
	logic              v_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              end_s1;

	// scan state
	phase_t                phase_q, phase_d;
	logic [KEY_LEN_W-1:0]  match_q, match_d;
	logic [WORD_IDX_W-1:0] words_q, words_d, words_inc;
	logic [BYTE_W-1:0]     prev_q, prev_d;
	logic [LEN_W-1:0]      len_q, len_d;

	// result register
	logic              out_v_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_fin_q;
	logic [LEN_W-1:0]  out_len_q;

	logic              advance, fire, in_ready;
	logic              res_v, res_fin, emit, term;
	logic [BYTE_W-1:0] res_byte;
	logic [LEN_W-1:0]  res_len;
	logic [KEY_LEN_W-1:0] eff_len;
	logic [KIDX_W-1:0]    key_idx;
	logic [BYTE_W-1:0]    key_b;

	assign advance  = !out_v_q || result.ready;
	assign fire     = v_s1 && advance;
	assign in_ready = !v_s1 || advance;

	always_comb begin
		eff_len = cfg.key_length;
		if (cfg.key_length == '0) begin
			eff_len = KEY_LEN_W'(1);
		end else if (cfg.key_length > KEY_LEN_W'(KeyBytes)) begin
			eff_len = KEY_LEN_W'(KeyBytes);
		end
	end

	assign key_idx = match_q[KIDX_W-1:0];
	assign key_b   = cfg.key_text[BYTE_W*key_idx +: BYTE_W];

	assign words_inc = words_q + WORD_IDX_W'(is_blank(prev_q) && !is_blank(byte_s1)
		&& (words_q != '1));

	assign term = (cfg.word_index == WORD_REST_OF_LINE) ?
		((byte_s1 == CH_LF) || (byte_s1 == CH_FF)) : is_blank(byte_s1);

	always_comb begin
		phase_d  = phase_q;
		match_d  = match_q;
		words_d  = words_q;
		prev_d   = prev_q;
		len_d    = len_q;
		res_v    = 1'b0;
		res_fin  = 1'b0;
		res_byte = '0;
		res_len  = '0;
		emit     = 1'b0;
		if (end_s1) begin
			if (phase_q != PH_DONE) begin
				res_v   = 1'b1;
				res_fin = 1'b1;
				res_len = len_q;
			end
			phase_d = PH_SEEK;
			match_d = '0;
			words_d = '0;
			prev_d  = '0;
			len_d   = '0;
		end else begin
			unique case (phase_q)
				PH_SEEK: begin
					prev_d  = byte_s1;
					match_d = (byte_s1 == key_b) ? match_q + KEY_LEN_W'(1) : '0;
					if (match_d >= eff_len) begin
						phase_d = PH_COUNT;
					end
				end
				PH_COUNT: begin
					prev_d  = byte_s1;
					words_d = words_inc;
					emit    = $signed({1'b0, words_inc}) >=
						$signed({cfg.word_index[WORD_IDX_W-1], cfg.word_index});
				end
				PH_EMIT: emit = 1'b1;
				PH_DONE: begin
				end
				default: begin
				end
			endcase
			if (emit) begin
				prev_d = byte_s1;
				res_v  = 1'b1;
				if (term) begin
					res_fin = 1'b1;
					res_len = len_q;
					phase_d = PH_DONE;
				end else begin
					res_byte = byte_s1;
					len_d    = (len_q == '1) ? len_q : len_q + LEN_W'(1);
					phase_d  = PH_EMIT;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && text.valid) begin
			byte_s1 <= text.text_byte;
			end_s1  <= text.string_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SEEK;
			match_q    <= '0;
			words_q    <= '0;
			prev_q     <= '0;
			len_q      <= '0;
			out_v_q    <= 1'b0;
			out_byte_q <= '0;
			out_fin_q  <= 1'b0;
			out_len_q  <= '0;
		end else begin
			if (fire) begin
				phase_q <= phase_d;
				match_q <= match_d;
				words_q <= words_d;
				prev_q  <= prev_d;
				len_q   <= len_d;
			end
			if (advance) begin
				out_v_q <= fire && res_v;
			end
			if (fire && res_v) begin
				out_byte_q <= res_byte;
				out_fin_q  <= res_fin;
				out_len_q  <= res_len;
			end
		end
	end

	assign text.ready        = in_ready;
	assign result.valid      = out_v_q;
	assign result.out_byte   = out_byte_q;
	assign result.finished   = out_fin_q;
	assign result.out_length = out_len_q;

	`HKV_ASSERT(a_fin_byte_zero, clk, arst_n, out_v_q && out_fin_q |-> out_byte_q == '0, "finished result carries a nonzero byte")
	`HKV_ASSERT(a_char_keeps_emit, clk, arst_n, fire && res_v && !res_fin |=> phase_q == PH_EMIT, "character result not followed by emit phase")
	`HKV_ASSERT(a_stall_full, clk, arst_n, !in_ready |-> v_s1 && out_v_q, "input stalled while a stage is free")
	`HKV_ASSERT(a_done_after_fin, clk, arst_n, fire && res_v && res_fin && !end_s1 |=> phase_q == PH_DONE, "terminator did not close the extraction")

endmodule

// ===== rtl/header_key_value_extractor_top.sv =====
// Top level of the header key/value extractor.
//
//  channel  | dir | payload                               | handshake
//  ---------+-----+---------------------------------------+--------------------
//  text     | in  | text_byte[7:0], string_end            | valid/ready
//  result   | out | out_byte[7:0], finished, out_length   | valid/ready
//  wr_*     | in  | wr_index[1:0], wr_data[63:0]          | wr_en, no back-pressure
//
// One byte per cycle sustained while the result side is ready; each byte passes
// from its transfer through the input register, then the scan logic, into the
// result register. The scan state updates as the byte leaves the input register.
// Reset clears scan state and loads key_length 1, word_index -1, key_text 0.
// A stalled result holds the result register and then the input register.
module header_key_value_extractor_top #(
	parameter int unsigned KeyBytes = hkv_pkg::KEY_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	hkv_in_if.sink                         text,
	hkv_out_if.source                      result,
	input  logic                           wr_en,
	input  logic [hkv_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [hkv_pkg::CFG_DATA_W-1:0] wr_data
);
	import hkv_pkg::*;

	hkv_cfg_t cfg;

	hkv_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	hkv_core #(
		.KeyBytes (KeyBytes)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.text   (text),
		.result (result)
	);

endmodule

// ===== dv/header_key_value_extractor_top_tb.sv =====
// Self-checking testbench for the header key/value extractor: keyed text streams against a scan predictor.
module header_key_value_extractor_top_tb;
	import hkv_pkg::*;

	localparam int unsigned RUN_LIMIT = 1_000_000;
	localparam int unsigned MAX_REPORTS = 10;
	localparam int unsigned TOTAL_ITEMS = 400;
	localparam int unsigned QUIET_ITEMS = 60;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic [WORD_IDX_W-1:0] WORD_MOST_NEGATIVE = 9'h100;
	localparam logic [WORD_IDX_W-1:0] WORD_MINUS_TWO = 9'h1FE;
	localparam logic [WORD_IDX_W-1:0] WORD_FAR = 9'd12;

	typedef enum logic [1:0] {SEEK_KEY, COUNT_WORDS, EMIT_WORD, SCAN_DONE} scan_phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] ch;
		logic              fin;
		logic [LEN_W-1:0]  len;
	} extract_t;

	function automatic bit is_space_char(input logic [BYTE_W-1:0] b);
		return b == CH_SPACE || b == CH_TAB || b == CH_LF;
	endfunction

	class extraction_scoreboard;
		logic [KEY_TEXT_W-1:0] key_text;
		logic [KEY_LEN_W-1:0]  key_length;
		logic [WORD_IDX_W-1:0] word_index;
		scan_phase_t           phase;
		logic [3:0]            matched;
		logic [8:0]            words;
		logic [BYTE_W-1:0]     last_byte;
		logic [LEN_W-1:0]      emitted;
		extract_t              expected_q[$];
		int unsigned           errors;

		function new();
			key_text = '0;
			key_length = 4'd1;
			word_index = WORD_REST_OF_LINE;
			errors = 0;
			restart();
		endfunction

		function void restart();
			phase = SEEK_KEY;
			matched = '0;
			words = '0;
			last_byte = '0;
			emitted = '0;
		endfunction

		function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
			case (idx)
			CFG_KEY_TEXT: key_text = data;
			CFG_KEY_LENGTH: key_length = data[KEY_LEN_W-1:0];
			CFG_WORD_INDEX: word_index = data[WORD_IDX_W-1:0];
			default: ;
			endcase
		endfunction

		function int key_span();
			if (key_length == 0)
				return 1;
			if (key_length > KEY_BYTES_DEF)
				return int'(KEY_BYTES_DEF);
			return int'(key_length);
		endfunction

		function void note_item(input logic [BYTE_W-1:0] b, input logic eos);
			int w;
			logic [BYTE_W-1:0] kb;
			bit stop;
			w = int'($signed(word_index));
			if (eos) begin
				if (phase != SCAN_DONE)
					expected_q.push_back('{ch: '0, fin: 1'b1, len: emitted});
				restart();
				return;
			end
			if (phase == SCAN_DONE)
				return;
			if (phase == SEEK_KEY) begin
				kb = key_text[8*matched[2:0] +: 8];
				if (b == kb)
					matched++;
				else
					matched = '0;
				if (matched >= key_span())
					phase = COUNT_WORDS;
				last_byte = b;
				return;
			end
			if (phase == COUNT_WORDS) begin
				if (is_space_char(last_byte) && !is_space_char(b) && words != 9'd511)
					words++;
				last_byte = b;
				if (int'(words) < w)
					return;
				phase = EMIT_WORD;
			end
			last_byte = b;
			stop = (w == -1) ? (b == CH_LF || b == CH_FF) : is_space_char(b);
			if (stop) begin
				expected_q.push_back('{ch: '0, fin: 1'b1, len: emitted});
				phase = SCAN_DONE;
			end else begin
				if (emitted != '1)
					emitted++;
				expected_q.push_back('{ch: b, fin: 1'b0, len: '0});
			end
		endfunction

		function void check_result(input logic [BYTE_W-1:0] ch, input logic fin,
				input logic [LEN_W-1:0] len);
			extract_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected result: byte %h finished %b length %0d", ch, fin, len);
				return;
			end
			want = expected_q.pop_front();
			if (want.ch !== ch || want.fin !== fin || want.len !== len) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("mismatch: expected byte %h finished %b length %0d, got %h %b %0d",
						want.ch, want.fin, want.len, ch, fin, len);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;
	bit                    quiet;
	int                    hold_off;
	int unsigned           sent;
	int unsigned           cycles;
	extraction_scoreboard  sb = new();

	hkv_in_if  text_if();
	hkv_out_if result_if();

	header_key_value_extractor_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text_if),
		.result   (result_if),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles <= RUN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int stall;
		stall = 0;
		result_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_if.valid && result_if.ready)
				sb.check_result(result_if.out_byte, result_if.finished, result_if.out_length);
			if (hold_off > 0) begin
				result_if.ready <= 1'b0;
				hold_off--;
			end else if (stall > 0) begin
				result_if.ready <= 1'b0;
				stall--;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 17) - 1;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	function automatic logic [BYTE_W-1:0] pick_blank();
		case ($urandom_range(0, 2))
		0: return CH_SPACE;
		1: return CH_TAB;
		default: return CH_LF;
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] pick_char();
		logic [BYTE_W-1:0] b;
		do
			b = BYTE_W'($urandom_range(0, 255));
		while (is_space_char(b));
		return b;
	endfunction

	task automatic send_item(input logic [BYTE_W-1:0] b, input logic eos);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 17);
			text_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_if.valid <= 1'b1;
		text_if.text_byte <= b;
		text_if.string_end <= eos;
		do
			@(posedge clk);
		while (!text_if.ready);
		sb.note_item(b, eos);
		sent++;
	endtask

	task automatic send_record();
		int w;
		int nwords;
		int n;
		w = int'($signed(sb.word_index));
		if ($urandom_range(0, 3) != 0) begin
			repeat ($urandom_range(0, 3)) send_item(BYTE_W'($urandom_range(0, 255)), 1'b0);
			for (int i = 0; i < sb.key_span(); i++)
				send_item(sb.key_text[8*i +: 8], 1'b0);
			nwords = (w > 0 ? w : 0) + $urandom_range(0, 2);
			repeat (nwords) begin
				repeat ($urandom_range(1, 2)) send_item(pick_blank(), 1'b0);
				repeat ($urandom_range(1, 4)) send_item(pick_char(), 1'b0);
			end
			if ($urandom_range(0, 3) != 0) begin
				if (w == -1)
					send_item($urandom_range(0, 1) ? CH_LF : CH_FF, 1'b0);
				else
					send_item(pick_blank(), 1'b0);
			end
			repeat ($urandom_range(0, 3)) send_item(BYTE_W'($urandom_range(0, 255)), 1'b0);
		end else begin
			n = $urandom_range(0, sb.key_span() - 1);
			for (int i = 0; i < n; i++)
				send_item(sb.key_text[8*i +: 8], 1'b0);
			repeat ($urandom_range(0, 10)) send_item(BYTE_W'($urandom_range(0, 255)), 1'b0);
		end
		if ($urandom_range(0, 9) != 0)
			send_item(BYTE_W'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic settle();
		text_if.valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic program_regs(input logic [KEY_TEXT_W-1:0] key, input logic [KEY_LEN_W-1:0] klen,
			input logic [WORD_IDX_W-1:0] widx);
		logic [CFG_DATA_W-1:0] d;
		put_reg(CFG_KEY_TEXT, key);
		d = {$urandom, $urandom};
		d[KEY_LEN_W-1:0] = klen;
		put_reg(CFG_KEY_LENGTH, d);
		d = {$urandom, $urandom};
		d[WORD_IDX_W-1:0] = widx;
		put_reg(CFG_WORD_INDEX, d);
		put_reg(CFG_UNUSED, {$urandom, $urandom});
		wr_en <= 1'b0;
	endtask

	task automatic run_phase(input logic [KEY_TEXT_W-1:0] key, input logic [KEY_LEN_W-1:0] klen,
			input logic [WORD_IDX_W-1:0] widx, input int unsigned records);
		settle();
		program_regs(key, klen, widx);
		repeat (records) send_record();
	endtask

	function automatic logic [WORD_IDX_W-1:0] pick_word_index();
		case ($urandom_range(0, 3))
		0: return WORD_REST_OF_LINE;
		1: return WORD_IDX_W'($urandom_range(0, 4));
		2: return WORD_IDX_W'(9'h1F8 + $urandom_range(0, 6));
		default: return WORD_IDX_W'($urandom_range(5, 9));
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		text_if.valid = 1'b0;
		text_if.text_byte = '0;
		text_if.string_end = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		quiet = 1'b0;
		hold_off = 0;
		sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero byte key, rest-of-line extraction
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(CH_SPACE, 1'b0);
		send_item(CH_LF, 1'b0);
		send_item(8'h41, 1'b0);
		send_item(8'hA5, 1'b1);
		send_item(8'h5A, 1'b1);
		send_item(8'h00, 1'b0);
		send_item(CH_FF, 1'b0);
		send_item(8'h00, 1'b1);
		send_item(8'h00, 1'b0);
		send_item(8'h7F, 1'b0);
		send_item(8'h00, 1'b1);

		// naive match drops the second 'i'; word zero starts right after the key
		settle();
		program_regs(64'h6469, 4'd2, '0);
		send_item(8'h69, 1'b0);
		send_item(8'h69, 1'b0);
		send_item(8'h64, 1'b0);
		send_item(8'h69, 1'b0);
		send_item(8'h64, 1'b0);
		send_item(8'h78, 1'b0);
		send_item(CH_TAB, 1'b0);
		send_item(8'h79, 1'b0);
		send_item(8'h00, 1'b1);

		run_phase({$urandom, $urandom}, 4'd0, '0, 2);
		run_phase({$urandom, $urandom}, 4'd15, WORD_MOST_NEGATIVE, 2);
		run_phase({$urandom, $urandom}, 4'd8, WORD_FAR, 1);
		run_phase({$urandom, $urandom}, 4'd1, WORD_MINUS_TWO, 2);
		run_phase('1, 4'd8, WORD_REST_OF_LINE, 2);
		run_phase('0, 4'd4, 9'd1, 2);

		// hold the result side while the sender keeps offering
		settle();
		program_regs({$urandom, $urandom}, 4'd3, 9'd1);
		hold_off = 300;
		repeat (6) send_record();

		while (sent + QUIET_ITEMS < TOTAL_ITEMS)
			run_phase({$urandom, $urandom}, KEY_LEN_W'($urandom_range(0, 15)),
				pick_word_index(), 2);

		quiet = 1'b1;
		do
			run_phase({$urandom, $urandom}, KEY_LEN_W'($urandom_range(1, 8)),
				pick_word_index(), 2);
		while (sent < TOTAL_ITEMS);

		settle();
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
